// ===== hw/rtl/erc_pkg.sv =====
package erc_pkg;

  // Escape marker of the compressed stream
  localparam logic [7:0] EscByte = 8'hFE;
  // Byte that follows the escape in a message terminator
  localparam logic [7:0] TermByte = 8'h00;
  // Reset value of the run cap register
  localparam logic [6:0] MaxRunReset = 7'd127;
  // Most output bytes one input transaction can produce
  localparam int unsigned MaxResults = 4;
  localparam int unsigned ResIdxW = $clog2(MaxResults);
  localparam int unsigned ResCntW = $clog2(MaxResults + 1);

  // Input command codes
  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } cmd_e;

  // Encoder state carried from one transaction to the next
  typedef struct packed {
    logic       started;
    logic [7:0] last_sent;
    logic [6:0] run;
  } enc_state_t;

  // Bytes produced by one transaction, entry 0 goes out first
  typedef struct packed {
    logic [ResCntW-1:0]               count;
    logic [MaxResults-1:0][7:0]       bytes;
    logic                             eom;
  } enc_result_t;

endpackage

// ===== hw/rtl/erc_encoder.sv =====
module erc_encoder (
  input  logic                 cmd_i,
  input  logic [7:0]           data_byte_i,
  input  logic [6:0]           max_run_i,
  input  erc_pkg::enc_state_t  state_i,
  output erc_pkg::enc_state_t  state_o,
  output erc_pkg::enc_result_t result_o
);

  logic [6:0]                        cap;
  logic [erc_pkg::ResCntW-1:0]       n;
  logic [erc_pkg::MaxResults-1:0][7:0] seq;
  logic [7:0]                        lst;
  logic [6:0]                        run;
  logic [6:0]                        run_inc;
  logic                              started;
  logic                              eom;
  logic                              do_fresh;

  // A cap of zero behaves as one
  assign cap     = (max_run_i == 7'd0) ? 7'd1 : max_run_i;
  assign run_inc = state_i.run + 7'd1;

  // Build the output sequence for one transaction
  always_comb begin
    n        = '0;
    seq      = '0;
    lst      = state_i.last_sent;
    run      = state_i.run;
    started  = state_i.started;
    eom      = 1'b0;
    do_fresh = 1'b0;

    // opening marker of a new message
    if (!started) begin
      seq[n[erc_pkg::ResIdxW-1:0]] = erc_pkg::EscByte;
      n       = n + 1'b1;
      lst     = erc_pkg::EscByte;
      started = 1'b1;
    end

    if (cmd_i == erc_pkg::CMD_END) begin
      // flush held run, then terminator
      if (run != 7'd0) begin
        seq[n[erc_pkg::ResIdxW-1:0]] = erc_pkg::EscByte;
        n = n + 1'b1;
        seq[n[erc_pkg::ResIdxW-1:0]] = {1'b0, run};
        n = n + 1'b1;
      end
      seq[n[erc_pkg::ResIdxW-1:0]] = erc_pkg::EscByte;
      n = n + 1'b1;
      seq[n[erc_pkg::ResIdxW-1:0]] = erc_pkg::TermByte;
      n       = n + 1'b1;
      eom     = 1'b1;
      started = 1'b0;
      lst     = erc_pkg::EscByte;
      run     = 7'd0;
    end else begin
      if (run != 7'd0) begin
        if ((data_byte_i == lst) && (run < cap)) begin
          // extend the run, send it once it hits the cap
          if (run_inc >= cap) begin
            seq[n[erc_pkg::ResIdxW-1:0]] = erc_pkg::EscByte;
            n = n + 1'b1;
            seq[n[erc_pkg::ResIdxW-1:0]] = {1'b0, run_inc};
            n   = n + 1'b1;
            lst = {1'b0, run_inc};
            run = 7'd0;
          end else begin
            run = run_inc;
          end
        end else begin
          // run broken: send it, then treat the byte as fresh
          seq[n[erc_pkg::ResIdxW-1:0]] = erc_pkg::EscByte;
          n = n + 1'b1;
          seq[n[erc_pkg::ResIdxW-1:0]] = {1'b0, run};
          n        = n + 1'b1;
          lst      = {1'b0, run};
          run      = 7'd0;
          do_fresh = 1'b1;
        end
      end else begin
        do_fresh = 1'b1;
      end

      // byte not part of a running repeat
      if (do_fresh) begin
        if (data_byte_i == erc_pkg::EscByte) begin
          seq[n[erc_pkg::ResIdxW-1:0]] = erc_pkg::EscByte;
          n = n + 1'b1;
          seq[n[erc_pkg::ResIdxW-1:0]] = erc_pkg::EscByte;
          n   = n + 1'b1;
          lst = erc_pkg::EscByte;
        end else if (data_byte_i == lst) begin
          if (cap == 7'd1) begin
            seq[n[erc_pkg::ResIdxW-1:0]] = erc_pkg::EscByte;
            n = n + 1'b1;
            seq[n[erc_pkg::ResIdxW-1:0]] = 8'd1;
            n   = n + 1'b1;
            lst = 8'd1;
          end else begin
            run = 7'd1;
          end
        end else begin
          seq[n[erc_pkg::ResIdxW-1:0]] = data_byte_i;
          n   = n + 1'b1;
          lst = data_byte_i;
        end
      end
    end
  end

  assign state_o.started   = started;
  assign state_o.last_sent = lst;
  assign state_o.run       = run;

  assign result_o.count = n;
  assign result_o.bytes = seq;
  assign result_o.eom   = eom;

endmodule

// ===== hw/rtl/escape_rle_byte_compressor_core.sv =====
// Escape-byte run-length compressor.
// Input channel (in_valid_i / in_stall_o): one transaction per message byte
// (cmd_i = 0, data_byte_i) or per end-of-message command (cmd_i = 1).
// Output channel (out_valid_o / out_stall_i): one compressed byte per
// transaction; last_of_item_o marks the final byte caused by an input
// transaction, end_of_message_o marks the closing 00 of the terminator.
// Config channel (cfg_valid_i / cfg_ready_o): writes max_run; always ready,
// write it only while the block is idle.
// The first byte of an input appears the cycle after it is taken.
// An input yields 0 to 4 bytes, drained one per cycle, unless the receiver
// stalls, from a 4-entry result buffer; the next input is taken in the cycle
// the previous input's last byte leaves.
// An input that holds a run (no bytes) leaves the buffer free for the next.
// A stalled receiver holds the buffer head and, through it, the input side.
// Reset empties the buffer, clears the message and run state and sets
// max_run to 127; no clearing pass is needed.
module escape_rle_byte_compressor_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_item_o,
  output logic       end_of_message_o
);

  logic [6:0]                          max_run_q;
  erc_pkg::enc_state_t                 state_q, state_d;
  erc_pkg::enc_result_t                result;
  logic [erc_pkg::MaxResults-1:0][7:0] buf_q, buf_d;
  logic [erc_pkg::ResCntW-1:0]         cnt_q, cnt_d;
  logic                                eom_q, eom_d;
  logic                                in_acc;
  logic                                out_take;
  logic                                buf_free;

  // Config register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_run_q <= erc_pkg::MaxRunReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_run_q <= cfg_data_i;
    end
  end

  // Handshakes
  assign out_valid_o = (cnt_q != '0);
  assign out_take    = out_valid_o && !out_stall_i;
  assign buf_free    = (cnt_q == '0) || ((cnt_q == 1) && out_take);
  assign in_stall_o  = !buf_free;
  assign in_acc      = in_valid_i && !in_stall_o;

  // Encoder logic
  erc_encoder u_encoder (
    .cmd_i       (cmd_i),
    .data_byte_i (data_byte_i),
    .max_run_i   (max_run_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .result_o    (result)
  );

  // Encoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.started   <= 1'b0;
      state_q.last_sent <= erc_pkg::EscByte;
      state_q.run       <= 7'd0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // Result buffer: load on accept, shift down on each output transaction
  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    eom_d = eom_q;
    if (out_take) begin
      for (int i = 0; i < erc_pkg::MaxResults - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      cnt_d = cnt_q - 1'b1;
    end
    if (in_acc) begin
      buf_d = result.bytes;
      cnt_d = result.count;
      eom_d = result.eom;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      eom_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      eom_q <= eom_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign out_byte_o       = buf_q[0];
  assign last_of_item_o   = (cnt_q == 1);
  assign end_of_message_o = (cnt_q == 1) && eom_q;

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= erc_pkg::MaxResults)
    else $error("result count out of range");

  a_eom_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_message_o |-> last_of_item_o && (out_byte_o == erc_pkg::TermByte))
    else $error("terminator byte misplaced");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (cmd_i == erc_pkg::CMD_END) |=> !state_q.started && (state_q.run == 7'd0)
      && (state_q.last_sent == erc_pkg::EscByte))
    else $error("state not cleared after terminator");

  a_run_in_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.run != 7'd0) |-> state_q.started)
    else $error("run held outside a message");

  a_drain_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !in_acc |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("buffer did not drain by one");

endmodule
